// ----- hw/rtl/ipv4dq_pkg.sv -----
// shared types and constants for the dotted-quad validator
`timescale 1ns / 1ps

package ipv4dq_pkg;

	localparam logic [7:0] ChZero  = 8'h30;
	localparam logic [7:0] ChNine  = 8'h39;
	localparam logic [7:0] ChDot   = 8'h2e;
	localparam logic [7:0] ChSpace = 8'h20;

	localparam logic [8:0] FieldMax = 9'd255;
	localparam logic [8:0] FieldSat = 9'd256;

	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

	typedef enum logic [1:0] {
		CLS_DIGIT,
		CLS_DOT,
		CLS_SPACE,
		CLS_OTHER
	} char_cls_t;

	// one classified character as it travels from front to back
	typedef struct packed {
		char_cls_t  cls;
		logic [3:0] digit;
		logic       last;
	} char_item_t;

	typedef struct packed {
		logic             full;
		logic             empty;
		logic [QCntW-1:0] count;
	} q_status_t;

endpackage

// ----- hw/rtl/ipv4dq_classify.sv -----
// front stage: takes characters and sorts them into digit, dot, space or other
`timescale 1ns / 1ps

module ipv4dq_classify import ipv4dq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       push,
	output char_item_t push_item,
	input  logic       q_full
);

	logic       valid_s1;
	char_item_t item_s1;
	char_item_t item_d;
	logic       accept;

	always_comb begin
		item_d.last  = last_char;
		item_d.digit = char_code[3:0];
		if (char_code >= ChZero && char_code <= ChNine) begin
			item_d.cls = CLS_DIGIT;
		end else if (char_code == ChDot) begin
			item_d.cls = CLS_DOT;
		end else if (char_code == ChSpace) begin
			item_d.cls = CLS_SPACE;
		end else begin
			item_d.cls = CLS_OTHER;
		end
	end

	assign in_stall  = valid_s1 && q_full;
	assign accept    = in_valid && !in_stall;
	assign push      = valid_s1 && !q_full;
	assign push_item = item_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (push) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= item_d;
		end
	end

endmodule

// ----- hw/rtl/ipv4dq_queue.sv -----
// short fifo of classified characters between front and back
`timescale 1ns / 1ps

module ipv4dq_queue import ipv4dq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  char_item_t push_item,
	input  logic       pop,
	output char_item_t head_item,
	output q_status_t  status
);

	char_item_t       mem_q [QDepth];
	logic [QPtrW-1:0] wr_ptr_q;
	logic [QPtrW-1:0] rd_ptr_q;
	logic [QCntW-1:0] count_q;

	assign head_item    = mem_q[rd_ptr_q];
	assign status.count = count_q;
	assign status.full  = (count_q == QCntW'(QDepth));
	assign status.empty = (count_q == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ----- hw/rtl/ipv4dq_parse.sv -----
// back stage: parse state machine and result register
`timescale 1ns / 1ps

module ipv4dq_parse import ipv4dq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  char_item_t head_item,
	input  logic       q_empty,
	output logic       pop,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_valid
);

	typedef enum logic [1:0] {
		PH_LEAD,
		PH_BODY,
		PH_TRAIL,
		PH_ERR
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [8:0]  value_q, value_d;
	logic        lead_zero_q, lead_zero_d;
	logic        has_digit_q, has_digit_d;
	logic [1:0]  dots_q, dots_d;
	logic        out_valid_q;
	logic        is_valid_q;
	logic        out_free;
	logic        field_ok;
	logic        field_ok_d;
	logic        result;
	logic [12:0] value_x10;

	assign out_free = !out_valid_q || !out_stall;
	assign pop      = !q_empty && (!head_item.last || out_free);

	assign field_ok = has_digit_q && !value_q[8] && !(value_q != '0 && lead_zero_q);
	assign value_x10 = {1'b0, value_q, 3'b000} + {3'b000, value_q, 1'b0}
		+ {9'd0, head_item.digit};

	always_comb begin
		phase_d     = phase_q;
		value_d     = value_q;
		lead_zero_d = lead_zero_q;
		has_digit_d = has_digit_q;
		dots_d      = dots_q;
		// leading spaces are skipped, anything else opens the body
		if (phase_q == PH_BODY || (phase_q == PH_LEAD && head_item.cls != CLS_SPACE)) begin
			phase_d = PH_BODY;
			unique case (head_item.cls)
				CLS_DIGIT: begin
					if (!has_digit_q) begin
						lead_zero_d = (head_item.digit == 4'd0);
						has_digit_d = 1'b1;
					end
					value_d = (value_x10 > 13'(FieldMax)) ? FieldSat : value_x10[8:0];
				end
				CLS_DOT: begin
					if (!field_ok || dots_q == 2'd3) begin
						phase_d = PH_ERR;
					end else begin
						dots_d      = dots_q + 1'b1;
						value_d     = '0;
						lead_zero_d = 1'b0;
						has_digit_d = 1'b0;
					end
				end
				CLS_SPACE: begin
					phase_d = PH_TRAIL;
				end
				CLS_OTHER: begin
					phase_d = PH_ERR;
				end
			endcase
		end else if (phase_q == PH_TRAIL && head_item.cls != CLS_SPACE) begin
			phase_d = PH_ERR;
		end
	end

	assign field_ok_d = has_digit_d && !value_d[8] && !(value_d != '0 && lead_zero_d);
	assign result = (phase_d == PH_BODY || phase_d == PH_TRAIL) && dots_d == 2'd3
		&& field_ok_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_LEAD;
			value_q     <= '0;
			lead_zero_q <= 1'b0;
			has_digit_q <= 1'b0;
			dots_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				if (head_item.last) begin
					// string done: back to the idle parse state
					phase_q     <= PH_LEAD;
					value_q     <= '0;
					lead_zero_q <= 1'b0;
					has_digit_q <= 1'b0;
					dots_q      <= '0;
				end else begin
					phase_q     <= phase_d;
					value_q     <= value_d;
					lead_zero_q <= lead_zero_d;
					has_digit_q <= has_digit_d;
					dots_q      <= dots_d;
				end
			end
			if (pop && head_item.last) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop && head_item.last) begin
			is_valid_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign is_valid  = is_valid_q;

endmodule

// ----- hw/rtl/ipv4_dotted_quad_validator.sv -----
// Checks a text string, one character per transfer, against the IPv4 dotted-quad form.
// One character is taken every clock cycle when the result side keeps up; the rate is set by
// the parse update in the back stage. A string's one-bit result is registered: its last
// character loads the classify register, then is written to the queue, and its parse loads
// the result register. A four-entry queue between classifier and parser lets the input keep
// flowing for a few characters while a result waits to be taken. Leading and trailing
// spaces are skipped; the result is 1 only for four non-empty decimal fields of at most 255,
// joined by three dots, with no leading zero on a nonzero field.
`timescale 1ns / 1ps

module ipv4_dotted_quad_validator import ipv4dq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] char_code,
	input  logic       last_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic       is_valid
);

	logic       push;
	logic       pop;
	char_item_t push_item;
	char_item_t head_item;
	q_status_t  q_status;

	ipv4dq_classify u_classify (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.push      (push),
		.push_item (push_item),
		.q_full    (q_status.full)
	);

	ipv4dq_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head_item (head_item),
		.status    (q_status)
	);

	ipv4dq_parse u_parse (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_item (head_item),
		.q_empty   (q_status.empty),
		.pop       (pop),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_valid  (is_valid)
	);

	// no push into a full queue, no pop from an empty one
	assert property (@(posedge clk) disable iff (!arst_n) push |-> !q_status.full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> !q_status.empty)
		else $error("pop from empty queue");

	// a new result only follows the parse of a last character
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(pop && head_item.last))
		else $error("result without a last character");

	assert property (@(posedge clk) disable iff (!arst_n)
		q_status.count <= QCntW'(QDepth))
		else $error("queue count out of range");

endmodule

// ----- dv/ipv4_dotted_quad_validator_tb.sv -----
// self-checking testbench for the dotted-quad validator, directed strings then random text
`timescale 1ns / 1ps

module ipv4_dotted_quad_validator_tb import ipv4dq_pkg::*; ();

	localparam int DirRows      = 18;
	localparam int UsePredictor = -1;
	localparam int CharTarget   = 750;

	typedef enum logic [1:0] {
		SCAN_LEAD,
		SCAN_BODY,
		SCAN_TRAIL,
		SCAN_BAD
	} scan_phase_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_stall;
	logic [7:0] char_code;
	logic       last_char;
	logic       out_valid;
	logic       out_stall;
	logic       is_valid;

	ipv4_dotted_quad_validator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.char_code (char_code),
		.last_char (last_char),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.is_valid  (is_valid)
	);

	// parser model state
	scan_phase_t scan_phase;
	logic [8:0]  acc_value;
	logic        acc_lead_zero;
	logic        acc_has_digit;
	logic [1:0]  dots_seen;

	logic       verdict_q[$];
	logic [7:0] line_buf[$];

	int  bad_count    = 0;
	int  lines_sent   = 0;
	int  chars_sent   = 0;
	int  results_seen = 0;
	int  valid_seen   = 0;
	int  stall_draw   = 0;
	int  stall_mark   = 0;
	int  stall_left   = 0;
	bit  calm         = 1'b0;

	string dir_text [DirRows] = '{
		"0.0.0.0",
		"255.255.255.255",
		"256.1.1.1",
		"9999.1.1.1",
		"1.2.3.04",
		"00.0.0.0",
		"   ",
		"1.2.3.4.5",
		"1..2.3",
		"1.2.3.",
		"1.2 .3.4",
		"1.2.3.4 x",
		"1.2.3.4/",
		"1.2.3.4\377",
		"  10.20.30.40  ",
		"1.2.3",
		" 192.168.1.1",
		"7"
	};
	int dir_want [DirRows] = '{
		1, 1, 0, 0, 0, UsePredictor, 0, 0, 0, 0, 0, 0, 0, 0,
		UsePredictor, 0, UsePredictor, 0
	};

	function automatic void quad_clear();
		scan_phase    = SCAN_LEAD;
		acc_value     = '0;
		acc_lead_zero = 1'b0;
		acc_has_digit = 1'b0;
		dots_seen     = '0;
	endfunction

	function automatic bit quad_field_ok();
		return acc_has_digit && (acc_value <= FieldMax) && !(acc_value != 0 && acc_lead_zero);
	endfunction

	function automatic void quad_take_body(input logic [7:0] c);
		int grown;
		if (c >= ChZero && c <= ChNine) begin
			if (!acc_has_digit) begin
				acc_lead_zero = (c == ChZero);
				acc_has_digit = 1'b1;
			end
			grown = int'(acc_value) * 10 + int'(c - ChZero);
			acc_value = (grown > int'(FieldMax)) ? FieldSat : 9'(grown);
		end else if (c == ChDot) begin
			if (!quad_field_ok() || dots_seen == 2'd3) begin
				scan_phase = SCAN_BAD;
			end else begin
				dots_seen++;
				acc_value     = '0;
				acc_lead_zero = 1'b0;
				acc_has_digit = 1'b0;
			end
		end else if (c == ChSpace) begin
			scan_phase = SCAN_TRAIL;
		end else begin
			scan_phase = SCAN_BAD;
		end
	endfunction

	// returns 1 when the character ends a string, with the verdict for it
	function automatic bit quad_step(input logic [7:0] c, input logic fin, output logic verdict);
		case (scan_phase)
			SCAN_LEAD: begin
				if (c != ChSpace) begin
					scan_phase = SCAN_BODY;
					quad_take_body(c);
				end
			end
			SCAN_BODY: quad_take_body(c);
			SCAN_TRAIL: begin
				if (c != ChSpace)
					scan_phase = SCAN_BAD;
			end
			default: ;
		endcase
		verdict = 1'b0;
		if (!fin)
			return 1'b0;
		verdict = (scan_phase == SCAN_BODY || scan_phase == SCAN_TRAIL) && dots_seen == 2'd3
			&& quad_field_ok();
		quad_clear();
		return 1'b1;
	endfunction

	function automatic void put_text(input string s);
		for (int i = 0; i < s.len(); i++)
			line_buf.push_back(s[i]);
	endfunction

	// mostly well-formed quads with random content, some of them damaged afterwards
	function automatic void make_quad();
		int    pos;
		string field;
		line_buf.delete();
		repeat ($urandom_range(0, 2)) line_buf.push_back(ChSpace);
		for (int f = 0; f < 4; f++) begin
			case ($urandom_range(0, 11))
				9:       field = {"0", $sformatf("%0d", $urandom_range(0, 255))};
				10:      field = $sformatf("%0d", $urandom_range(256, 999));
				11:      field = ($urandom_range(0, 1) == 0) ? "00"
					: $sformatf("%0d", $urandom_range(1000, 99999));
				default: field = $sformatf("%0d", $urandom_range(0, 255));
			endcase
			put_text(field);
			if (f < 3)
				line_buf.push_back(ChDot);
		end
		repeat ($urandom_range(0, 2)) line_buf.push_back(ChSpace);
		if ($urandom_range(0, 4) == 0) begin
			pos = $urandom_range(0, line_buf.size() - 1);
			case ($urandom_range(0, 3))
				0:       line_buf[pos] = 8'($urandom_range(0, 255));
				1:       line_buf.delete(pos);
				2:       line_buf.insert(pos, ChDot);
				default: line_buf.insert(pos, ChSpace);
			endcase
		end
	endfunction

	function automatic void make_noise();
		line_buf.delete();
		repeat ($urandom_range(1, 8)) begin
			if ($urandom_range(0, 1) == 0)
				line_buf.push_back(8'($urandom_range(0, 255)));
			else
				line_buf.push_back(8'(ChZero + $urandom_range(0, 11)));
		end
		// digits plus the two chars just past nine, swapped for dot and space
		foreach (line_buf[i]) begin
			if (line_buf[i] == ChNine + 8'd1)
				line_buf[i] = ChDot;
			else if (line_buf[i] == ChNine + 8'd2)
				line_buf[i] = ChSpace;
		end
	endfunction

	// called at a falling edge, returns at the falling edge after the transfer
	task automatic send_char(input logic [7:0] c, input logic fin);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 19);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid  <= 1'b1;
		char_code <= c;
		last_char <= fin;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic send_line(input int want);
		logic fin;
		logic verdict;
		calm = ($urandom_range(0, 3) == 0);
		foreach (line_buf[i]) begin
			fin = (i == line_buf.size() - 1);
			send_char(line_buf[i], fin);
			chars_sent++;
			if (quad_step(line_buf[i], fin, verdict))
				verdict_q.push_back((want == UsePredictor) ? verdict : logic'(want));
		end
		lines_sent++;
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("== FAIL ==");
		$finish;
	end

	// result side: hold off for a drawn number of cycles before each transfer
	always @(negedge clk) begin
		if (stall_mark != results_seen) begin
			stall_mark = results_seen;
			stall_left = stall_draw;
		end
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		logic want;
		if (arst_n && out_valid && !out_stall) begin
			if (verdict_q.size() == 0) begin
				$error("is_valid: no result expected, actual %0b", is_valid);
				bad_count++;
			end else begin
				want = verdict_q.pop_front();
				if (is_valid !== want) begin
					$error("is_valid: expected %0b, actual %0b", want, is_valid);
					bad_count++;
				end
			end
			results_seen++;
			if (is_valid === 1'b1)
				valid_seen++;
			stall_draw = calm ? 0 : $urandom_range(0, 19);
		end
	end

	initial begin
		arst_n    = 1'b0;
		in_valid  = 1'b0;
		char_code = '0;
		last_char = 1'b0;
		quad_clear();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		for (int r = 0; r < DirRows; r++) begin
			line_buf.delete();
			put_text(dir_text[r]);
			send_line(dir_want[r]);
		end

		while (chars_sent < CharTarget) begin
			if ($urandom_range(0, 3) == 0)
				make_noise();
			else
				make_quad();
			send_line(UsePredictor);
		end
		in_valid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("sent %0d strings (%0d characters), %0d directed", lines_sent, chars_sent,
			DirRows);
		$display("checked %0d results, %0d of them valid addresses", results_seen, valid_seen);
		if (bad_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
